// ----- src/assert_macros.svh -----
// assertion helpers shared by the scheduler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that must hold at every clock edge outside reset
`define PTS_ASSERT(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// an antecedent that must imply the consequent on the next edge
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// shared codes and the controller to datapath command and status types
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam logic [1:0] FUNC_READY  = 2'd0;
	localparam logic [1:0] FUNC_WAKE   = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;
	localparam logic [1:0] FUNC_SWITCH = 2'd3;

	localparam logic [1:0] LEAVE_RUN   = 2'd0;
	localparam logic [1:0] LEAVE_SLEEP = 2'd1;
	localparam logic [1:0] LEAVE_WAIT  = 2'd2;
	localparam logic [1:0] LEAVE_EXIT  = 2'd3;

	localparam logic [2:0] ST_FREE     = 3'd0;
	localparam logic [2:0] ST_READY    = 3'd1;
	localparam logic [2:0] ST_RUNNING  = 3'd2;
	localparam logic [2:0] ST_SLEEPING = 3'd3;
	localparam logic [2:0] ST_WAITING  = 3'd4;
	localparam logic [2:0] ST_ZOMBIE   = 3'd5;

	// one-step operations the controller asks of the datapath
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;  // latch the item
	localparam logic [3:0] OP_DECODE   = 4'd2;  // look up status, set flags
	localparam logic [3:0] OP_RM_STEP  = 4'd3;  // one step of sleep removal search
	localparam logic [3:0] OP_RM_DONE  = 4'd4;  // unlink found entry
	localparam logic [3:0] OP_APPEND   = 4'd5;  // append target to ready queue
	localparam logic [3:0] OP_TICK_CHK = 4'd6;  // compare sleep head time
	localparam logic [3:0] OP_TICK_POP = 4'd7;  // take sleep head as target
	localparam logic [3:0] OP_LEAVE    = 4'd8;  // current leaves
	localparam logic [3:0] OP_INS_STEP = 4'd9;  // one step of sorted insert
	localparam logic [3:0] OP_INS_DONE = 4'd10; // link the new sleeper
	localparam logic [3:0] OP_RESCHED  = 4'd11; // pick the next thread
	localparam logic [3:0] OP_PREEMPT  = 4'd12; // requeue preempted thread
	localparam logic [3:0] OP_FINISH   = 4'd13; // present result

	typedef struct packed {
		logic [3:0] op;
	} pts_cmd_t;

	typedef struct packed {
		logic       act_ready;   // make ready needs work
		logic       act_wake;    // wake needs work
		logic       need_remove; // target is sleeping
		logic       tick_more;   // sleep head due
		logic       walk_done;   // list walk finished
		logic       do_leave_sleep;
		logic       preempt;     // previous thread must be requeued
	} pts_sts_t;

endpackage

// ----- src/pts_datapath.sv -----
// ----------------------------------------------------------------------------
// pts_datapath
// thread tables, ready queues and sorted sleep list, one step per command
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pts_datapath #(
	parameter int THREADS         = 32,
	parameter int PRIORITY_LEVELS = 8,
	parameter int TIME_BITS       = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pts_pkg::pts_cmd_t cmd,
	output pts_pkg::pts_sts_t sts,
	input  logic [1:0]        func,
	input  logic [4:0]        thread_num,
	input  logic [2:0]        priority_req,
	input  logic [1:0]        leave_state,
	input  logic [31:0]       resume_time,
	input  logic [31:0]       now_time,
	output logic [4:0]        current_thread,
	output logic              switched,
	output logic              need_resched,
	output logic              none_ready,
	output logic              error
);
	import pts_pkg::*;

	localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
	localparam int CW = $clog2(THREADS + 1);
	localparam int TB = (TIME_BITS < 32) ? TIME_BITS : 32;

	logic [2:0]           status_q [THREADS];
	logic [PW-1:0]        prio_q   [THREADS];
	logic [TW-1:0]        rlink_q  [THREADS];
	logic [TW-1:0]        rhead_q  [PRIORITY_LEVELS];
	logic [TW-1:0]        rtail_q  [PRIORITY_LEVELS];
	logic [PRIORITY_LEVELS-1:0] rne_q;
	logic [TIME_BITS-1:0] stime_q  [THREADS];
	logic [TW-1:0]        slink_q  [THREADS];
	logic [TW-1:0]        shead_q;
	logic [CW-1:0]        scount_q;
	logic [TW-1:0]        run_q;
	logic                 run_valid_q;

	// latched item
	logic [1:0]           func_q;
	logic                 id_ok_q;
	logic [PW-1:0]        pr_q;
	logic [1:0]           leave_q;
	logic [TIME_BITS-1:0] resume_q, now_q;

	// working registers
	logic [TW-1:0] tgt_q, prev_q, cur_q;
	logic [CW-1:0] pos_q;
	logic          found_q;
	logic          sw_q, need_q, none_q, err_q;
	logic          act_ready_q, act_wake_q, rm_q, leave_sleep_q, preempt_q;

	// priority select, highest non-empty level
	logic [PW-1:0] top_lvl;
	logic          top_any;
	always_comb begin
		top_lvl = '0;
		top_any = 1'b0;
		for (int i = 0; i < PRIORITY_LEVELS; i++) begin
			if (rne_q[i]) begin
				top_lvl = PW'(i);
				top_any = 1'b1;
			end
		end
	end

	logic [PW-1:0] pr_sat;
	always_comb begin
		if ({29'd0, priority_req} >= 32'(PRIORITY_LEVELS))
			pr_sat = PW'(PRIORITY_LEVELS - 1);
		else
			pr_sat = PW'(priority_req);
	end

	logic [2:0]    tgt_status;
	logic [PW-1:0] tgt_prio;
	logic [PW-1:0] run_prio;
	assign tgt_status = status_q[tgt_q];
	assign tgt_prio   = prio_q[tgt_q];
	assign run_prio   = prio_q[run_q];

	assign sts.act_ready      = act_ready_q;
	assign sts.act_wake       = act_wake_q;
	assign sts.need_remove    = rm_q;
	assign sts.tick_more      = (scount_q != '0) && (stime_q[shead_q] <= now_q);
	assign sts.walk_done      = found_q || (pos_q >= scount_q);
	assign sts.do_leave_sleep = leave_sleep_q;
	assign sts.preempt        = preempt_q;

	// pick decision is combinational on the registered tables
	logic pick_c, prev_run_c;
	assign prev_run_c = run_valid_q && (status_q[run_q] == ST_RUNNING);
	assign pick_c = top_any && (!prev_run_c || top_lvl >= run_prio);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) status_q[i] <= ST_FREE;
			rne_q       <= '0;
			shead_q     <= '0;
			scount_q    <= '0;
			run_q       <= '0;
			run_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_RM_DONE: begin
					if (!found_q) begin
					end else begin
						if (pos_q == '0) shead_q <= slink_q[tgt_q];
						scount_q <= scount_q - 1'b1;
					end
				end
				OP_APPEND: begin
					status_q[tgt_q] <= ST_READY;
					rne_q[tgt_prio] <= 1'b1;
				end
				OP_TICK_POP: begin
					shead_q  <= slink_q[shead_q];
					scount_q <= scount_q - 1'b1;
				end
				OP_LEAVE: begin
					if (run_valid_q && status_q[run_q] == ST_RUNNING) begin
						case (leave_q)
							LEAVE_SLEEP: status_q[run_q] <= ST_SLEEPING;
							LEAVE_WAIT:  status_q[run_q] <= ST_WAITING;
							LEAVE_EXIT:  status_q[run_q] <= ST_ZOMBIE;
							default: ;
						endcase
					end
				end
				OP_INS_DONE: begin
					if (pos_q == '0) shead_q <= run_q;
					scount_q <= scount_q + 1'b1;
				end
				OP_RESCHED: begin
					if (pick_c) begin
						if (rhead_q[top_lvl] == rtail_q[top_lvl]) rne_q[top_lvl] <= 1'b0;
						status_q[rhead_q[top_lvl]] <= ST_RUNNING;
						run_q       <= rhead_q[top_lvl];
						run_valid_q <= 1'b1;
					end else if (!prev_run_c) begin
						run_valid_q <= 1'b0;
					end
				end
				OP_PREEMPT: begin
					status_q[tgt_q] <= ST_READY;
					rne_q[tgt_prio] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q   <= func;
				id_ok_q  <= ({27'd0, thread_num} < 32'(THREADS));
				pr_q     <= pr_sat;
				leave_q  <= leave_state;
				resume_q <= TIME_BITS'(resume_time[TB-1:0]);
				now_q    <= TIME_BITS'(now_time[TB-1:0]);
				tgt_q    <= TW'(thread_num);
				sw_q <= 1'b0; need_q <= 1'b0; none_q <= 1'b0; err_q <= 1'b0;
				act_ready_q <= 1'b0; act_wake_q <= 1'b0; rm_q <= 1'b0;
				leave_sleep_q <= 1'b0; preempt_q <= 1'b0;
				pos_q <= '0; found_q <= 1'b0;
			end
			OP_DECODE: begin
				pos_q   <= '0;
				found_q <= 1'b0;
				cur_q   <= shead_q;
				rm_q    <= (tgt_status == ST_SLEEPING);
				if (func_q == FUNC_READY) begin
					act_ready_q <= id_ok_q && tgt_status != ST_READY &&
						tgt_status != ST_RUNNING;
				end else if (func_q == FUNC_WAKE) begin
					if (!id_ok_q || tgt_status == ST_FREE || tgt_status >= ST_ZOMBIE)
						err_q <= 1'b1;
					act_wake_q <= id_ok_q && (tgt_status == ST_SLEEPING ||
						tgt_status == ST_WAITING);
				end else if (func_q == FUNC_SWITCH) begin
					leave_sleep_q <= prev_run_c && leave_q == LEAVE_SLEEP;
				end
			end
			OP_RM_STEP: begin
				if (cur_q == tgt_q) begin
					found_q <= 1'b1;
				end else begin
					prev_q <= cur_q;
					cur_q  <= slink_q[cur_q];
					pos_q  <= pos_q + 1'b1;
				end
			end
			OP_RM_DONE: begin
				if (found_q && pos_q != '0) slink_q[prev_q] <= slink_q[tgt_q];
				if (act_ready_q) prio_q[tgt_q] <= pr_q;
			end
			OP_APPEND: begin
				if (rne_q[tgt_prio]) rlink_q[rtail_q[tgt_prio]] <= tgt_q;
				else rhead_q[tgt_prio] <= tgt_q;
				rtail_q[tgt_prio] <= tgt_q;
				if (act_wake_q && (!run_valid_q || tgt_prio > run_prio)) need_q <= 1'b1;
			end
			OP_TICK_POP: tgt_q <= shead_q;
			OP_LEAVE: begin
				if (leave_sleep_q) stime_q[run_q] <= resume_q;
				cur_q <= shead_q;
				pos_q <= '0;
				found_q <= 1'b0;
			end
			OP_INS_STEP: begin
				if (resume_q > stime_q[cur_q]) begin
					prev_q <= cur_q;
					cur_q  <= slink_q[cur_q];
					pos_q  <= pos_q + 1'b1;
				end else begin
					found_q <= 1'b1;
				end
			end
			OP_INS_DONE: begin
				slink_q[run_q] <= cur_q;
				if (pos_q != '0) slink_q[prev_q] <= run_q;
			end
			OP_RESCHED: begin
				tgt_q      <= run_q;
				preempt_q  <= pick_c && prev_run_c;
				if (pick_c) begin
					if (rhead_q[top_lvl] != rtail_q[top_lvl])
						rhead_q[top_lvl] <= rlink_q[rhead_q[top_lvl]];
					sw_q <= !(run_valid_q && rhead_q[top_lvl] == run_q);
				end else if (!prev_run_c) begin
					none_q <= 1'b1;
				end
			end
			OP_PREEMPT: begin
				if (rne_q[tgt_prio]) rlink_q[rtail_q[tgt_prio]] <= tgt_q;
				else rhead_q[tgt_prio] <= tgt_q;
				rtail_q[tgt_prio] <= tgt_q;
			end
			default: ;
		endcase
	end

	// result is driven while the controller strobes it
	assign current_thread = run_valid_q ? 5'(run_q) : 5'd0;
	assign switched       = sw_q;
	assign need_resched   = need_q;
	assign none_ready     = none_q;
	assign error          = err_q;

	`PTS_ASSERT(a_count_range, clk, arst_n, scount_q <= CW'(THREADS),
		"sleep count beyond thread count")
	`PTS_ASSERT_NEXT(a_resched_runs, clk, arst_n, cmd.op == OP_RESCHED && pick_c,
		run_valid_q, "picked thread not marked running")
	`PTS_ASSERT_NEXT(a_none_clear, clk, arst_n,
		cmd.op == OP_RESCHED && !pick_c && !prev_run_c, !run_valid_q,
		"nothing ready but a thread still marked running")

endmodule

// ----- src/pts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pts_ctrl
// sequencer that steps the datapath through one operation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        func,
	output logic              busy,
	output logic              done,
	output pts_pkg::pts_cmd_t cmd,
	input  pts_pkg::pts_sts_t sts
);
	import pts_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_RM_STEP = 4'd2;
	localparam logic [3:0] S_RM_DONE = 4'd3;
	localparam logic [3:0] S_APPEND  = 4'd4;
	localparam logic [3:0] S_TCHK    = 4'd5;
	localparam logic [3:0] S_TPOP    = 4'd6;
	localparam logic [3:0] S_TAPP    = 4'd7;
	localparam logic [3:0] S_LEAVE   = 4'd8;
	localparam logic [3:0] S_INS     = 4'd9;
	localparam logic [3:0] S_INS_DN  = 4'd10;
	localparam logic [3:0] S_RESCHED = 4'd11;
	localparam logic [3:0] S_PREEMPT = 4'd12;
	localparam logic [3:0] S_FINISH  = 4'd13;
	localparam logic [3:0] S_LEAVE2  = 4'd14;

	logic [3:0] state_q, state_d;
	logic [1:0] func_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q  <= FUNC_READY;
		end else begin
			state_q <= state_d;
			if (start && !busy) func_q <= func;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FINISH);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.op = OP_DECODE;
				case (func_q)
					FUNC_TICK:   state_d = S_TCHK;
					FUNC_SWITCH: state_d = S_LEAVE;
					default:     state_d = S_RM_STEP;
				endcase
			end
			S_RM_STEP: begin
				if (!(sts.act_ready || sts.act_wake)) state_d = S_FINISH;
				else if (!sts.need_remove || sts.walk_done) state_d = S_RM_DONE;
				else cmd.op = OP_RM_STEP;
			end
			S_RM_DONE: begin
				cmd.op  = sts.need_remove ? OP_RM_DONE : OP_NONE;
				if (!sts.need_remove && sts.act_ready) cmd.op = OP_RM_DONE;
				state_d = S_APPEND;
			end
			S_APPEND: begin
				cmd.op  = OP_APPEND;
				state_d = S_FINISH;
			end
			S_TCHK: begin
				state_d = sts.tick_more ? S_TPOP : S_RESCHED;
			end
			S_TPOP: begin
				cmd.op  = OP_TICK_POP;
				state_d = S_TAPP;
			end
			S_TAPP: begin
				cmd.op  = OP_APPEND;
				state_d = S_TCHK;
			end
			S_LEAVE: begin
				cmd.op  = OP_LEAVE;
				state_d = sts.do_leave_sleep ? S_INS : S_RESCHED;
			end
			S_INS: begin
				if (sts.walk_done) state_d = S_INS_DN;
				else cmd.op = OP_INS_STEP;
			end
			S_INS_DN: begin
				cmd.op  = OP_INS_DONE;
				state_d = S_RESCHED;
			end
			S_RESCHED: begin
				cmd.op  = OP_RESCHED;
				state_d = S_LEAVE2;
			end
			S_LEAVE2: begin
				state_d = sts.preempt ? S_PREEMPT : S_FINISH;
			end
			S_PREEMPT: begin
				cmd.op  = OP_PREEMPT;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	`PTS_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy,
		"accepted item did not make the block busy")
	`PTS_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy,
		"result strobe not followed by idle")
	`PTS_ASSERT(a_done_busy, clk, arst_n, !done || busy,
		"result strobe while idle")

endmodule

// ----- src/priority_thread_scheduler.sv -----
// ----------------------------------------------------------------------------
// priority_thread_scheduler
// fixed-priority preemptive thread scheduler with ready fifos and sleep list
// ----------------------------------------------------------------------------
// Give one item with start high while busy is low: func selects make ready,
// wake, tick or switch. Exactly one result follows, on the result ports for
// one cycle with done high; the receiver cannot stall it, so it must take
// the result in that cycle. busy stays high from acceptance to that cycle,
// and the next item can be taken in the cycle after it, so one item is worked
// at a time. Removal from the sleep list and the sorted insert of a sleeping
// switch walk the list one entry per cycle. A tick moves the due sleepers to
// the ready fifos one at a time and then picks the next thread, so a tick that
// wakes every thread sets the worst case. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module priority_thread_scheduler #(
	parameter int THREADS         = 32,
	parameter int PRIORITY_LEVELS = 8,
	parameter int TIME_BITS       = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  func,
	input  logic [4:0]  thread_num,
	input  logic [2:0]  priority_req,
	input  logic [1:0]  leave_state,
	input  logic [31:0] resume_time,
	input  logic [31:0] now_time,
	output logic [4:0]  current_thread,
	output logic        switched,
	output logic        need_resched,
	output logic        none_ready,
	output logic        error
);
	import pts_pkg::*;

	// command and status between sequencer and tables
	pts_cmd_t cmd;
	pts_sts_t sts;

	pts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	pts_datapath #(
		.THREADS         (THREADS),
		.PRIORITY_LEVELS (PRIORITY_LEVELS),
		.TIME_BITS       (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.func           (func),
		.thread_num     (thread_num),
		.priority_req   (priority_req),
		.leave_state    (leave_state),
		.resume_time    (resume_time),
		.now_time       (now_time),
		.current_thread (current_thread),
		.switched       (switched),
		.need_resched   (need_resched),
		.none_ready     (none_ready),
		.error          (error)
	);

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the priority thread scheduler: a scoreboard keeps
// its own copy of thread status, ready fifos and the sorted sleep list, and
// compares every result with its prediction
// ----------------------------------------------------------------------------
module testbench;
	import pts_pkg::*;

	localparam int N_THR = 32;
	localparam int N_LVL = 8;

	typedef struct {
		logic [4:0] cur;
		logic       sw;
		logic       nr;
		logic       nn;
		logic       er;
	} sched_res_t;

	// scheduler shadow plus the queue of predicted results
	class sched_scoreboard;
		logic [2:0]  status [N_THR];
		logic [2:0]  prio   [N_THR];
		logic [4:0]  rlink  [N_THR];
		logic [4:0]  rhead  [N_LVL];
		logic [4:0]  rtail  [N_LVL];
		logic [7:0]  rne;
		logic [31:0] stime  [N_THR];
		logic [4:0]  slink  [N_THR];
		logic [4:0]  shead;
		int          scount;
		logic [4:0]  run_t;
		logic        run_v;
		sched_res_t  pending [$];
		int          n_fail;
		int          n_checked;

		function new();
			foreach (status[i]) status[i] = ST_FREE;
			rne = '0; shead = '0; scount = 0; run_t = '0; run_v = 1'b0;
			n_fail = 0; n_checked = 0;
		endfunction

		function void ready_append(logic [4:0] t);
			logic [2:0] p;
			p = prio[t];
			status[t] = ST_READY;
			if (rne[p]) rlink[rtail[p]] = t;
			else rhead[p] = t;
			rtail[p] = t;
			rne[p] = 1'b1;
		endfunction

		function logic [4:0] ready_pop(logic [2:0] p);
			logic [4:0] t;
			t = rhead[p];
			if (rhead[p] == rtail[p]) rne[p] = 1'b0;
			else rhead[p] = rlink[t];
			return t;
		endfunction

		// ties go in front of equal times
		function void sleep_insert(logic [4:0] t, logic [31:0] wt);
			logic [4:0] prv, cur;
			int pos;
			prv = '0; cur = shead; pos = 0;
			stime[t] = wt;
			while (pos < scount && wt > stime[cur]) begin
				prv = cur; cur = slink[cur]; pos++;
			end
			slink[t] = cur;
			if (pos == 0) shead = t;
			else slink[prv] = t;
			scount++;
		endfunction

		function void sleep_remove(logic [4:0] t);
			logic [4:0] prv, cur;
			int pos;
			prv = '0; cur = shead; pos = 0;
			while (pos < scount && cur != t) begin
				prv = cur; cur = slink[cur]; pos++;
			end
			if (pos >= scount) return;
			if (pos == 0) shead = slink[t];
			else slink[prv] = slink[t];
			scount--;
		endfunction

		function void resched(ref sched_res_t r);
			logic prev_run;
			logic [4:0] nxt;
			prev_run = run_v && status[run_t] == ST_RUNNING;
			for (int i = N_LVL - 1; i >= 0; i--) begin
				if (!rne[i]) continue;
				if (!prev_run || i >= prio[run_t]) begin
					nxt = ready_pop(3'(i));
					if (prev_run) ready_append(run_t);
					status[nxt] = ST_RUNNING;
					r.sw = !(run_v && nxt == run_t);
					run_t = nxt;
					run_v = 1'b1;
					return;
				end
				break;
			end
			if (!prev_run) begin
				run_v = 1'b0;
				r.nn = 1'b1;
			end
		endfunction

		// an accepted item: step the shadow and queue its result
		function void note_item(logic [1:0] f, logic [4:0] id, logic [2:0] pr,
				logic [1:0] lv, logic [31:0] rt, logic [31:0] nw);
			sched_res_t r;
			logic [2:0] s;
			logic [4:0] h;
			r = '{default: '0};
			s = status[id];
			case (f)
				FUNC_READY: begin
					if (s != ST_READY && s != ST_RUNNING) begin
						if (s == ST_SLEEPING) sleep_remove(id);
						prio[id] = pr;
						ready_append(id);
					end
				end
				FUNC_WAKE: begin
					if (s == ST_FREE || s >= ST_ZOMBIE) r.er = 1'b1;
					else if (s == ST_SLEEPING || s == ST_WAITING) begin
						if (s == ST_SLEEPING) sleep_remove(id);
						ready_append(id);
						if (!run_v || prio[id] > prio[run_t]) r.nr = 1'b1;
					end
				end
				FUNC_TICK: begin
					while (scount != 0 && stime[shead] <= nw) begin
						h = shead;
						sleep_remove(h);
						ready_append(h);
					end
					resched(r);
				end
				default: begin
					if (run_v && status[run_t] == ST_RUNNING) begin
						if (lv == LEAVE_SLEEP) begin
							status[run_t] = ST_SLEEPING;
							sleep_insert(run_t, rt);
						end else if (lv == LEAVE_WAIT) status[run_t] = ST_WAITING;
						else if (lv == LEAVE_EXIT) status[run_t] = ST_ZOMBIE;
					end
					resched(r);
				end
			endcase
			r.cur = run_v ? run_t : '0;
			pending.push_back(r);
		endfunction

		function void check_result(sched_res_t a);
			sched_res_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: cur=%0d", a.cur);
				n_fail++;
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (a.cur !== e.cur) begin
				$error("current_thread exp %0d got %0d", e.cur, a.cur); n_fail++;
			end
			if (a.sw !== e.sw) begin
				$error("switched exp %0b got %0b", e.sw, a.sw); n_fail++;
			end
			if (a.nr !== e.nr) begin
				$error("need_resched exp %0b got %0b", e.nr, a.nr); n_fail++;
			end
			if (a.nn !== e.nn) begin
				$error("none_ready exp %0b got %0b", e.nn, a.nn); n_fail++;
			end
			if (a.er !== e.er) begin
				$error("error exp %0b got %0b", e.er, a.er); n_fail++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy, done;
	logic [1:0]  func = FUNC_READY;
	logic [4:0]  thread_num = '0;
	logic [2:0]  priority_req = '0;
	logic [1:0]  leave_state = LEAVE_RUN;
	logic [31:0] resume_time = '0;
	logic [31:0] now_time = '0;
	logic [4:0]  current_thread;
	logic        switched, need_resched, none_ready, error;

	sched_scoreboard sb = new();
	logic [31:0] sys_now;     // time base kept by the stimulus
	int          op_count [4];

	priority_thread_scheduler u_top (.*);

	initial forever #5 clk = ~clk;

	// result capture: done is sampled with pre-edge values
	always @(posedge clk)
		if (arst_n && done)
			sb.check_result('{current_thread, switched, need_resched, none_ready, error});

	// present one item and hold it until the edge that accepts it
	task automatic send_item(logic [1:0] f, logic [4:0] id, logic [2:0] pr,
			logic [1:0] lv, logic [31:0] rt, logic [31:0] nw);
		func <= f; thread_num <= id; priority_req <= pr;
		leave_state <= lv; resume_time <= rt; now_time <= nw;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_item(f, id, pr, lv, rt, nw);
		op_count[f]++;
	endtask

	// sender pause: start drops when the pause is not empty
	task automatic idle_for(int n);
		if (n > 0) start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// one random item, mostly plausible kernel traffic
	task automatic random_item();
		int sel;
		logic [31:0] rt;
		sel = $urandom_range(0, 99);
		rt = ($urandom_range(0, 9) == 0) ? $urandom : sys_now + $urandom_range(0, 120);
		if (sel < 28)
			send_item(FUNC_READY, 5'($urandom), 3'($urandom), 2'($urandom), $urandom, $urandom);
		else if (sel < 40)
			send_item(FUNC_WAKE, 5'($urandom), 3'($urandom), 2'($urandom), $urandom, $urandom);
		else if (sel < 60) begin
			sys_now = sys_now + $urandom_range(0, 60);
			send_item(FUNC_TICK, 5'($urandom), 3'($urandom), 2'($urandom), rt,
				($urandom_range(0, 19) == 0) ? $urandom : sys_now);
		end else
			send_item(FUNC_SWITCH, 5'($urandom), 3'($urandom), 2'($urandom), rt, $urandom);
	endtask

	initial begin
		int burst;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty block, extremes, every leave path and every wake error
		send_item(FUNC_TICK,   5'd0,  3'd0, LEAVE_RUN,   '0, 32'd0);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_EXIT,  '0, '0);
		send_item(FUNC_WAKE,   5'd5,  3'd0, LEAVE_RUN,   '0, '0);
		send_item(FUNC_READY,  5'd0,  3'd0, LEAVE_RUN,   '0, '0);
		send_item(FUNC_READY,  5'd31, 3'd7, LEAVE_RUN,   '0, '0);
		send_item(FUNC_READY,  5'd31, 3'd2, LEAVE_RUN,   '0, '0);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_RUN,   '0, '0);
		send_item(FUNC_READY,  5'd31, 3'd0, LEAVE_RUN,   '0, '0);
		send_item(FUNC_WAKE,   5'd31, 3'd0, LEAVE_RUN,   '0, '0);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_SLEEP, 32'hFFFF_FFFF, '0);
		send_item(FUNC_WAKE,   5'd31, 3'd0, LEAVE_RUN,   '0, '0);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_WAIT,  '0, '0);
		send_item(FUNC_WAKE,   5'd31, 3'd0, LEAVE_RUN,   '0, '0);
		send_item(FUNC_READY,  5'd7,  3'd7, LEAVE_RUN,   '0, '0);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_RUN,   '0, '0);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_SLEEP, 32'd0, '0);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_SLEEP, 32'd0, '0);
		send_item(FUNC_READY,  5'd31, 3'd4, LEAVE_RUN,   '0, '0);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_EXIT,  '0, '0);
		send_item(FUNC_WAKE,   5'd31, 3'd0, LEAVE_RUN,   '0, '0);
		send_item(FUNC_TICK,   5'd0,  3'd0, LEAVE_RUN,   '0, 32'hFFFF_FFFF);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_EXIT,  '0, '0);
		send_item(FUNC_SWITCH, 5'd0,  3'd0, LEAVE_EXIT,  '0, '0);
		send_item(FUNC_READY,  5'd31, 3'd5, LEAVE_RUN,   '0, '0);

		// random part in bursts, some with no gaps at all
		sys_now = $urandom_range(0, 1000);
		for (int n = 0; n < 650; ) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst; k++) begin
				random_item();
				n++;
			end
			if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d make ready, %0d wake, %0d tick and %0d switch items",
			op_count[FUNC_READY], op_count[FUNC_WAKE], op_count[FUNC_TICK],
			op_count[FUNC_SWITCH]);
		$display("%0d results compared field by field", sb.n_checked);
		if (sb.n_fail == 0 && sb.pending.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#20000000;
		$display("testbench NOT OK");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+src
src/pts_pkg.sv
src/pts_datapath.sv
src/pts_ctrl.sv
src/priority_thread_scheduler.sv
dv/testbench.sv
